FILE: src/fst_pkg.sv
// Package for the staged fan-coil thermostat: field widths, mode codes,
// configuration register indexes, reset values and the configuration bundle.
// No dependencies.
package fst_pkg;

    localparam int NUM_UNITS_DEF = 7;

    localparam int IDX_W     = 3;
    localparam int TEMP_W    = 16;
    localparam int SP_W      = 10;
    localparam int SET_W     = 3;
    localparam int MODE_W    = 2;
    localparam int SPEED_W   = 2;
    localparam int THR_W     = 11;
    localparam int HYS_W     = 9;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_COOL = 2'd1,
        MODE_HEAT = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_HEAT_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIPE_HYS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_HYS = 3'd3;

    localparam logic [THR_W-1:0] HEAT_THR_RST = 11'd350;
    localparam logic [THR_W-1:0] COOL_THR_RST = 11'd180;
    localparam logic [HYS_W-1:0] PIPE_HYS_RST = 9'd20;
    localparam logic [HYS_W-1:0] ROOM_HYS_RST = 9'd20;

    localparam logic [SET_W-1:0]   AUTO_SETTING = 3'd4;
    localparam logic [SPEED_W-1:0] SPEED_STOP   = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_LOW    = 2'd1;
    localparam logic [SPEED_W-1:0] SPEED_MID    = 2'd2;
    localparam logic [SPEED_W-1:0] SPEED_HIGH   = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0] heat_thr;
        logic [THR_W-1:0] cool_thr;
        logic [HYS_W-1:0] pipe_hys;
        logic [HYS_W-1:0] room_hys;
    } cfg_t;

endpackage

FILE: src/fst_core.sv
// Per-update decision logic: water hysteresis picks the mode, room
// temperature against setpoint picks the fan stage. Purely combinational.
// Depends on fst_pkg.
module fst_core
    import fst_pkg::*;
(
    input  cfg_t                cfg,
    input  logic [TEMP_W-1:0]   water_temp,
    input  logic [TEMP_W-1:0]   room_temp,
    input  logic [SP_W-1:0]     room_setpoint,
    input  logic [SET_W-1:0]    speed_setting,
    input  mode_t               old_mode,
    input  logic [SPEED_W-1:0]  old_speed,
    output mode_t               new_mode,
    output logic [SPEED_W-1:0]  new_speed
);

    logic signed [17:0] water_x, room_x, sp_x;
    logic signed [17:0] heat_x, cool_x, pipe_x;
    logic signed [17:0] half_x, h_x, ohalf_x;
    logic [10:0]        three_h;
    logic               lt_ohalf, lt_h, lt_half, lt_phalf;
    logic               gt_ohalf, gt_h, gt_half, gt_mhalf;
    logic [SPEED_W-1:0] man_set;
    logic [SPEED_W-1:0] spd;
    logic               is_auto;

    assign water_x = {{2{water_temp[TEMP_W-1]}}, water_temp};
    assign room_x  = {{2{room_temp[TEMP_W-1]}}, room_temp};
    assign sp_x    = {8'd0, room_setpoint};
    assign heat_x  = {{7{cfg.heat_thr[THR_W-1]}}, cfg.heat_thr};
    assign cool_x  = {{7{cfg.cool_thr[THR_W-1]}}, cfg.cool_thr};
    assign pipe_x  = {9'd0, cfg.pipe_hys};

    assign three_h = {1'b0, cfg.room_hys, 1'b0} + {2'd0, cfg.room_hys};
    assign half_x  = {10'd0, cfg.room_hys[HYS_W-1:1]};
    assign h_x     = {9'd0, cfg.room_hys};
    assign ohalf_x = {8'd0, three_h[10:1]};

    assign lt_ohalf = room_x < sp_x - ohalf_x;
    assign lt_h     = room_x < sp_x - h_x;
    assign lt_half  = room_x < sp_x - half_x;
    assign lt_phalf = room_x < sp_x + half_x;
    assign gt_ohalf = room_x > sp_x + ohalf_x;
    assign gt_h     = room_x > sp_x + h_x;
    assign gt_half  = room_x > sp_x + half_x;
    assign gt_mhalf = room_x > sp_x - half_x;

    assign is_auto = speed_setting >= AUTO_SETTING;
    assign man_set = speed_setting[SPEED_W-1:0];

    always_comb begin
        if (water_x > heat_x + pipe_x || (water_x > heat_x && old_mode == MODE_HEAT)) begin
            new_mode = MODE_HEAT;
        end else if (water_x < cool_x - pipe_x ||
                     (water_x < cool_x && old_mode == MODE_COOL)) begin
            new_mode = MODE_COOL;
        end else begin
            new_mode = MODE_OFF;
        end
    end

    always_comb begin
        spd = old_speed;
        case (new_mode)
            MODE_HEAT: begin
                if (is_auto) begin
                    if (lt_ohalf || (lt_h && old_speed == SPEED_HIGH))
                        spd = SPEED_HIGH;
                    else if (lt_h || (lt_half && old_speed >= SPEED_MID))
                        spd = SPEED_MID;
                    else if (lt_half || (lt_phalf && old_speed >= SPEED_LOW))
                        spd = SPEED_LOW;
                    else
                        spd = SPEED_STOP;
                end else begin
                    if (lt_half)
                        spd = man_set;
                    if (gt_half || spd != man_set)
                        spd = SPEED_STOP;
                end
            end
            MODE_COOL: begin
                if (is_auto) begin
                    if (gt_ohalf || (gt_h && old_speed == SPEED_HIGH))
                        spd = SPEED_HIGH;
                    else if (gt_h || (gt_half && old_speed >= SPEED_MID))
                        spd = SPEED_MID;
                    else if (gt_half || (gt_mhalf && old_speed >= SPEED_LOW))
                        spd = SPEED_LOW;
                    else
                        spd = SPEED_STOP;
                end else begin
                    if (lt_half || spd != man_set)
                        spd = SPEED_STOP;
                    if (gt_half)
                        spd = man_set;
                end
            end
            default: spd = SPEED_STOP;
        endcase
        new_speed = spd;
    end

endmodule

FILE: src/fancoil_staged_thermostat.sv
// Staged fan-coil thermostat for a bank of fan-coil units.
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while m_tready is high; the
// per-unit mode/speed tables are read and written in the same cycle.
// Reset (aresetn low, synchronous): config to defaults, all units off/stopped.
// Depends on fst_pkg and fst_core.
module fancoil_staged_thermostat
    import fst_pkg::*;
#(
    parameter int NUM_UNITS = NUM_UNITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // unit_index, water_temp, room_temp, room_setpoint, speed_setting
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // unit_number, unit_mode, fan_speed, zero pad
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int TAB_IW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int EXT_W  = (TAB_IW > IDX_W) ? TAB_IW : IDX_W;

    cfg_t cfg_reg;

    mode_t              mode_tab_reg  [NUM_UNITS];
    logic [SPEED_W-1:0] speed_tab_reg [NUM_UNITS];

    logic                in_valid_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TEMP_W-1:0]   water_reg;
    logic [TEMP_W-1:0]   room_reg;
    logic [SP_W-1:0]     sp_reg;
    logic [SET_W-1:0]    set_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;

    logic                advance;
    logic                in_range;
    logic [EXT_W-1:0]    idx_ext;
    logic [TAB_IW-1:0]   tab_idx;
    mode_t               new_mode;
    logic [SPEED_W-1:0]  new_speed;
    mode_t               res_mode;
    logic [SPEED_W-1:0]  res_speed;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign idx_ext  = EXT_W'(idx_reg);
    assign tab_idx  = idx_ext[TAB_IW-1:0];
    assign in_range = 32'(idx_reg) < NUM_UNITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heat_thr <= HEAT_THR_RST;
            cfg_reg.cool_thr <= COOL_THR_RST;
            cfg_reg.pipe_hys <= PIPE_HYS_RST;
            cfg_reg.room_hys <= ROOM_HYS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEAT_THR: cfg_reg.heat_thr <= cfg_wdata[THR_W-1:0];
                REG_COOL_THR: cfg_reg.cool_thr <= cfg_wdata[THR_W-1:0];
                REG_PIPE_HYS: cfg_reg.pipe_hys <= cfg_wdata[HYS_W-1:0];
                REG_ROOM_HYS: cfg_reg.room_hys <= cfg_wdata[HYS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            idx_reg   <= s_tdata[2:0];
            water_reg <= s_tdata[18:3];
            room_reg  <= s_tdata[34:19];
            sp_reg    <= s_tdata[44:35];
            set_reg   <= s_tdata[47:45];
        end
    end

    fst_core u_core (
        .cfg           (cfg_reg),
        .water_temp    (water_reg),
        .room_temp     (room_reg),
        .room_setpoint (sp_reg),
        .speed_setting (set_reg),
        .old_mode      (mode_tab_reg[tab_idx]),
        .old_speed     (speed_tab_reg[tab_idx]),
        .new_mode      (new_mode),
        .new_speed     (new_speed)
    );

    assign res_mode      = in_range ? new_mode : MODE_OFF;
    assign res_speed     = in_range ? new_speed : SPEED_STOP;
    assign out_data_next = {1'b0, res_speed, res_mode, idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                mode_tab_reg[i]  <= MODE_OFF;
                speed_tab_reg[i] <= SPEED_STOP;
            end
        end else if (advance && in_range) begin
            mode_tab_reg[tab_idx]  <= new_mode;
            speed_tab_reg[tab_idx] <= new_speed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
